// ===== hw/rtl/alu16_flags_execute_defines.svh =====
// assertion macros for the alu16 flags execute block
// used by the top level only, expects clk and arst_n in scope
`ifndef ALU16_FLAGS_EXECUTE_DEFINES_SVH
`define ALU16_FLAGS_EXECUTE_DEFINES_SVH

// same-cycle implication
`define AFX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AFX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/alu16fx_pkg.sv =====
// shared constants and types for the alu16 flags execute block
// no dependencies
package alu16fx_pkg;

	localparam int REG_COUNT = 4;
	localparam int REG_AW    = $clog2(REG_COUNT);
	localparam int DATA_W    = 16;
	localparam int FLAG_W    = 5;
	localparam int OP_W      = 5;
	localparam int BYTE_W    = 8;

	// flag bit positions
	localparam int FLAG_C = 0;
	localparam int FLAG_G = 1;
	localparam int FLAG_E = 2;
	localparam int FLAG_L = 3;
	localparam int FLAG_V = 4;

	// opcodes
	localparam logic [OP_W-1:0] OP_LOAD = 5'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 5'd2;
	localparam logic [OP_W-1:0] OP_ADC  = 5'd3;
	localparam logic [OP_W-1:0] OP_SUB  = 5'd4;
	localparam logic [OP_W-1:0] OP_SBB  = 5'd5;
	localparam logic [OP_W-1:0] OP_AND  = 5'd6;
	localparam logic [OP_W-1:0] OP_XOR  = 5'd7;
	localparam logic [OP_W-1:0] OP_NOT  = 5'd8;
	localparam logic [OP_W-1:0] OP_SHL  = 5'd9;
	localparam logic [OP_W-1:0] OP_ASL  = 5'd10;
	localparam logic [OP_W-1:0] OP_SHR  = 5'd11;
	localparam logic [OP_W-1:0] OP_ASR  = 5'd12;
	localparam logic [OP_W-1:0] OP_CMP  = 5'd13;
	localparam logic [OP_W-1:0] OP_FTR  = 5'd14;
	localparam logic [OP_W-1:0] OP_RTF  = 5'd15;
	localparam logic [OP_W-1:0] OP_NOP  = 5'd25;
	// first code of the invalid range
	localparam logic [OP_W-1:0] OP_INVALID_BASE = 5'd26;

	typedef enum logic [1:0] {
		OUT_EXEC      = 2'd0,
		OUT_UNHANDLED = 2'd1,
		OUT_INVALID   = 2'd2
	} outcome_t;

endpackage

// ===== hw/rtl/alu16_flags_execute.sv =====
// an accepted instruction is registered in the operand stage, then in the output register that drives m_axis_tvalid
// throughput: one instruction per cycle while m_axis_tready is high; a result can wait in the output register
// while the next instruction sits in the operand stage
// register file reads happen at acceptance with bypass from the writeback of the stage ahead
// reset clears the flag word, the register file valid bits (registers read as zero) and
// all valid flags; no clearing pass is needed
// top level of the alu16 flags execute block
// depends on alu16fx_pkg, alu16fx_ram and alu16_flags_execute_defines.svh
`include "alu16_flags_execute_defines.svh"

module alu16_flags_execute
	import alu16fx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // opcode[4:0], dest_reg[6:5], low_byte[14:7], zero pad
	input  logic        s_axis_tuser,  // imm_flag
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // dest_value[15:0], flags[20:16], outcome[22:21], zero pad
);

	// input field split
	logic [OP_W-1:0]   in_opcode;
	logic [REG_AW-1:0] in_rd;
	logic [BYTE_W-1:0] in_lb;
	logic [REG_AW-1:0] in_rs;

	assign in_opcode = s_axis_tdata[4:0];
	assign in_rd     = s_axis_tdata[6:5];
	assign in_lb     = s_axis_tdata[14:7];
	assign in_rs     = in_lb[7:6];

	// operand stage
	logic              s1_valid_q;
	logic [OP_W-1:0]   opcode_s1;
	logic [REG_AW-1:0] rd_s1;
	logic              imm_s1;
	logic [BYTE_W-1:0] lb_s1;
	logic              fwd_a_s1, fwd_b_s1;
	logic              vld_a_s1, vld_b_s1;
	logic [DATA_W-1:0] byp_a_s1, byp_b_s1;

	// architectural state
	logic [FLAG_W-1:0]    flag_q;
	logic [REG_COUNT-1:0] valid_q;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic [FLAG_W-1:0] out_flags_q;
	outcome_t          out_outcome_q;

	logic accept, advance;
	logic wr_en;
	logic [DATA_W-1:0] ram_a, ram_b;

	// execute logic
	logic [DATA_W-1:0] op_a, op_b, cnst, nb, add_x, res;
	logic [DATA_W:0]   cterm, sum17;
	logic              add_ovf, cin;
	logic [FLAG_W-1:0] flags_n;
	outcome_t          outcome_n;

	assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign wr_en         = advance && (outcome_n == OUT_EXEC);

	alu16fx_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (rd_s1),
		.wdata (res),
		.re    (accept),
		.raddr (in_rd),
		.rdata (ram_a)
	);

	alu16fx_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (rd_s1),
		.wdata (res),
		.re    (accept),
		.raddr (in_rs),
		.rdata (ram_b)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			flag_q      <= '0;
			valid_q     <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				flag_q      <= flags_n;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				valid_q[rd_s1] <= 1'b1;
			end
		end
	end

	// operand stage payload, bypassing the register written at this edge
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= in_opcode;
			rd_s1     <= in_rd;
			imm_s1    <= s_axis_tuser;
			lb_s1     <= in_lb;
			fwd_a_s1  <= wr_en && (rd_s1 == in_rd);
			fwd_b_s1  <= wr_en && (rd_s1 == in_rs);
			vld_a_s1  <= valid_q[in_rd];
			vld_b_s1  <= valid_q[in_rs];
			byp_a_s1  <= res;
			byp_b_s1  <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_value_q   <= (outcome_n == OUT_EXEC) ? res : op_a;
			out_flags_q   <= flags_n;
			out_outcome_q <= outcome_n;
		end
	end

	always_comb begin
		op_a  = fwd_a_s1 ? byp_a_s1 : (vld_a_s1 ? ram_a : '0);
		cnst  = {{(DATA_W-BYTE_W){lb_s1[BYTE_W-1]}}, lb_s1};
		op_b  = imm_s1 ? cnst : (fwd_b_s1 ? byp_b_s1 : (vld_b_s1 ? ram_b : '0));
		nb    = ~op_b + 16'd1;
		cin   = flag_q[FLAG_C];

		// shared adder: add, add with carry, subtract, subtract with borrow, shift left
		add_x = op_b;
		cterm = '0;
		unique case (opcode_s1)
			OP_ADC:  cterm = {{DATA_W{1'b0}}, cin};
			OP_SUB:  add_x = nb;
			OP_SBB: begin
				add_x = nb;
				cterm = {(DATA_W+1){cin}};
			end
			OP_SHL:  add_x = op_a;
			default: ;
		endcase
		sum17   = {1'b0, op_a} + {1'b0, add_x} + cterm;
		add_ovf = (op_a[DATA_W-1] == add_x[DATA_W-1]) && (sum17[DATA_W-1] != op_a[DATA_W-1]);

		res       = op_a;
		flags_n   = flag_q;
		outcome_n = OUT_EXEC;
		unique case (opcode_s1)
			OP_LOAD: begin
				if (imm_s1) begin
					res = cnst;
				end else begin
					outcome_n = OUT_UNHANDLED;
				end
			end
			OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_SHL: begin
				res             = sum17[DATA_W-1:0];
				flags_n[FLAG_C] = sum17[DATA_W];
				flags_n[FLAG_V] = add_ovf;
			end
			OP_AND: res = op_a & op_b;
			OP_XOR: res = op_a ^ op_b;
			OP_NOT: res = ~op_a;
			OP_ASL: begin
				res             = {op_a[DATA_W-1], op_a[DATA_W-3:0], 1'b0};
				flags_n[FLAG_C] = op_a[DATA_W-1];
				flags_n[FLAG_V] = 1'b0;
			end
			OP_SHR, OP_ASR: begin
				res             = {(opcode_s1 == OP_ASR) & op_a[DATA_W-1], op_a[DATA_W-1:1]};
				flags_n[FLAG_C] = op_a[0];
			end
			OP_CMP: begin
				flags_n[FLAG_G] = 1'b0;
				flags_n[FLAG_E] = 1'b0;
				flags_n[FLAG_L] = 1'b0;
				// signed order from unsigned compare and sign agreement
				if (op_a == op_b) begin
					flags_n[FLAG_E] = 1'b1;
				end else if ((op_a < op_b) == (op_a[DATA_W-1] == op_b[DATA_W-1])) begin
					flags_n[FLAG_L] = 1'b1;
				end else begin
					flags_n[FLAG_G] = 1'b1;
				end
			end
			OP_FTR: res = {{(DATA_W-FLAG_W){1'b0}}, flag_q};
			OP_RTF: flags_n = op_a[FLAG_W-1:0];
			OP_NOP: ;
			default: begin
				outcome_n = (opcode_s1 >= OP_INVALID_BASE) ? OUT_INVALID : OUT_UNHANDLED;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_outcome_q, out_flags_q, out_value_q};

	`AFX_ASSERT_NEXT(a_flags_kept, advance && (outcome_n != OUT_EXEC), flag_q == $past(flag_q), "flags changed by a non-executed instruction")
	`AFX_ASSERT_NEXT(a_cmp_onehot, advance && (opcode_s1 == OP_CMP), $onehot(flag_q[FLAG_L:FLAG_G]), "compare did not set exactly one order flag")
	`AFX_ASSERT_NEXT(a_s1_hold, s1_valid_q && !advance, s1_valid_q && $stable(opcode_s1) && $stable(rd_s1), "stalled operand stage lost its instruction")
	`AFX_ASSERT_NOW(a_no_write_stall, wr_en, advance && s1_valid_q, "register write without instruction retiring")

endmodule

// ===== hw/rtl/alu16fx_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module alu16fx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
